/* rtl/lpdr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpdr_pkg: shared constants and types of the line point distance ratio block
// Holds the default widths, the register indexes and the flag bundle that
// travels with each item along the divider and square-root cells.
// ----------------------------------------------------------------------------
package lpdr_pkg;

  // Default coordinate width and fraction bits of the ratio.
  localparam int LPDR_COORD_WIDTH = 16;
  localparam int LPDR_FRAC_BITS   = 15;

  // Width of a squared distance for the default coordinate width.
  localparam int LPDR_SPAN_WIDTH  = 2 * LPDR_COORD_WIDTH + 1;

  // The quotient is kept to 32 bits; anything larger saturates.
  localparam int LPDR_WORD_W      = 32;
  // The root of a 32-bit quotient has 16 bits, one per square-root cell.
  localparam int LPDR_ALPHA_W     = LPDR_WORD_W / 2;
  // Partial remainder of the square root: root plus two bits.
  localparam int LPDR_SQ_REM_W    = LPDR_ALPHA_W + 2;

  localparam logic [LPDR_ALPHA_W-1:0] LPDR_ALPHA_MAX = '1;

  // Configuration register indexes.
  localparam int LPDR_CFG_IDX_W = 2;
  localparam logic [LPDR_CFG_IDX_W-1:0] REG_START_X = 2'd0;
  localparam logic [LPDR_CFG_IDX_W-1:0] REG_START_Y = 2'd1;
  localparam logic [LPDR_CFG_IDX_W-1:0] REG_END_X   = 2'd2;
  localparam logic [LPDR_CFG_IDX_W-1:0] REG_END_Y   = 2'd3;

  // Status carried with every item through the cell chain.
  typedef struct packed {
    logic sat;    // quotient is 2^32 or more
    logic degen;  // start and end points coincide
  } lpdr_flags_t;

endpackage
`default_nettype wire

/* rtl/lpdr_point_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpdr_point_if: pixel coordinate channel
// Carries one line pixel per item under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpdr_point_if
  import lpdr_pkg::*;
#(
  parameter int COORD_WIDTH = LPDR_COORD_WIDTH
) ();

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);

endinterface
`default_nettype wire

/* rtl/lpdr_ratio_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpdr_ratio_if: distance ratio result channel
// Carries one ratio and its degenerate flag per item under valid/ready.
// ----------------------------------------------------------------------------
interface lpdr_ratio_if
  import lpdr_pkg::*;
();

  logic                    valid;
  logic                    ready;
  logic [LPDR_ALPHA_W-1:0] alpha;
  logic                    degenerate;

  modport source (output valid, output alpha, output degenerate, input ready);
  modport sink   (input valid, input alpha, input degenerate, output ready);

endinterface
`default_nettype wire

/* rtl/lpdr_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpdr_front: squared distance and divider set-up
// Four stages: absolute differences, squares, sum, then the saturation
// check and the initial partial remainder for the divider cells.
// ----------------------------------------------------------------------------
module lpdr_front
  import lpdr_pkg::*;
#(
  parameter int COORD_WIDTH = LPDR_COORD_WIDTH,
  parameter int FRAC_BITS   = LPDR_FRAC_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [COORD_WIDTH-1:0]          start_x_i,
  input  wire logic [COORD_WIDTH-1:0]          start_y_i,
  input  wire logic [2*COORD_WIDTH:0]          span_i,
  input  wire logic                            up_valid_i,
  output      logic                            up_ready_o,
  input  wire logic [COORD_WIDTH-1:0]          point_x_i,
  input  wire logic [COORD_WIDTH-1:0]          point_y_i,
  output      logic                            dn_valid_o,
  input  wire logic                            dn_ready_i,
  output      logic [2*COORD_WIDTH:0]          rem_o,
  output      logic [LPDR_WORD_W-1:0]          word_o,
  output      lpdr_flags_t                     flags_o
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = 2 * COORD_WIDTH + 1;
  localparam int NT = DW + 2 * FRAC_BITS;
  localparam int NE = NT + LPDR_WORD_W;
  localparam int NS = 4;

  logic [NS-1:0] v_q, v_d, rdy, in_v, ld;

  logic signed [CW:0] dx, dy;
  logic [CW:0]        ndx, ndy;
  logic [CW-1:0]      ux, uy;
  logic [NE-1:0]      n_ext;
  logic [NT-1:0]      high;
  logic [NT-1:0]      span_ext;

  logic [CW-1:0]      s1_ux_q, s1_uy_q;
  logic [2*CW-1:0]    s2_sqx_q, s2_sqy_q;
  logic [DW-1:0]      s3_d2_q;
  logic [DW-1:0]      s4_rem_q;
  logic [LPDR_WORD_W-1:0] s4_word_q;
  lpdr_flags_t        s4_flags_q;

  // Ready ripples back from the divider; a stage loads when it is empty
  // or its item moves on in the same cycle.
  always_comb begin
    in_v = {v_q[NS-2:0], up_valid_i};
    rdy[NS-1] = !v_q[NS-1] || dn_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    for (int k = 0; k < NS; k++) begin
      v_d[k] = rdy[k] ? in_v[k] : v_q[k];
      ld[k]  = rdy[k] && in_v[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // Stage 1: absolute coordinate differences from the start point.
  always_comb begin
    dx  = $signed({point_x_i[CW-1], point_x_i}) - $signed({start_x_i[CW-1], start_x_i});
    dy  = $signed({point_y_i[CW-1], point_y_i}) - $signed({start_y_i[CW-1], start_y_i});
    ndx = -dx;
    ndy = -dy;
    ux  = dx[CW] ? ndx[CW-1:0] : dx[CW-1:0];
    uy  = dy[CW] ? ndy[CW-1:0] : dy[CW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      s1_ux_q <= ux;
      s1_uy_q <= uy;
    end
  end

  // Stage 2: squares.
  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      s2_sqx_q <= {{CW{1'b0}}, s1_ux_q} * {{CW{1'b0}}, s1_ux_q};
      s2_sqy_q <= {{CW{1'b0}}, s1_uy_q} * {{CW{1'b0}}, s1_uy_q};
    end
  end

  // Stage 3: squared distance.
  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      s3_d2_q <= {1'b0, s2_sqx_q} + {1'b0, s2_sqy_q};
    end
  end

  // Stage 4: the scaled distance split into the part above the 32 quotient
  // bits and the 32 bits that the divider cells shift in. The quotient
  // saturates when the upper part already reaches the span.
  always_comb begin
    n_ext    = {{LPDR_WORD_W{1'b0}}, s3_d2_q, {(2 * FRAC_BITS){1'b0}}};
    high     = n_ext[NE-1:LPDR_WORD_W];
    span_ext = {{(NT - DW){1'b0}}, span_i};
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      s4_rem_q         <= high[DW-1:0];
      s4_word_q        <= n_ext[LPDR_WORD_W-1:0];
      s4_flags_q.sat   <= high >= span_ext;
      s4_flags_q.degen <= span_i == '0;
    end
  end

  assign up_ready_o = rdy[0];
  assign dn_valid_o = v_q[NS-1];
  assign rem_o      = s4_rem_q;
  assign word_o     = s4_word_q;
  assign flags_o    = s4_flags_q;

endmodule
`default_nettype wire

/* rtl/lpdr_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpdr_div_cell: one restoring division step
// Shifts the next dividend bit into the partial remainder, subtracts the
// span where it fits and shifts the quotient bit into the data word.
// ----------------------------------------------------------------------------
module lpdr_div_cell
  import lpdr_pkg::*;
#(
  parameter int SPAN_WIDTH = LPDR_SPAN_WIDTH
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [SPAN_WIDTH-1:0]   span_i,
  input  wire logic                    up_valid_i,
  output      logic                    up_ready_o,
  input  wire logic [SPAN_WIDTH-1:0]   rem_i,
  input  wire logic [LPDR_WORD_W-1:0]  word_i,
  input  wire lpdr_flags_t             flags_i,
  output      logic                    dn_valid_o,
  input  wire logic                    dn_ready_i,
  output      logic [SPAN_WIDTH-1:0]   rem_o,
  output      logic [LPDR_WORD_W-1:0]  word_o,
  output      lpdr_flags_t             flags_o
);

  logic                   valid_q;
  logic                   ld;
  logic [SPAN_WIDTH:0]    trial;
  logic [SPAN_WIDTH:0]    diff;
  logic                   fits;
  logic [SPAN_WIDTH-1:0]  rem_q;
  logic [LPDR_WORD_W-1:0] word_q;
  lpdr_flags_t            flags_q;

  assign up_ready_o = !valid_q || dn_ready_i;
  assign ld         = up_valid_i && up_ready_o;

  // Trial subtraction of the span from the shifted remainder.
  always_comb begin
    trial = {rem_i, word_i[LPDR_WORD_W-1]};
    diff  = trial - {1'b0, span_i};
    fits  = trial >= {1'b0, span_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      rem_q   <= fits ? diff[SPAN_WIDTH-1:0] : trial[SPAN_WIDTH-1:0];
      word_q  <= {word_i[LPDR_WORD_W-2:0], fits};
      flags_q <= flags_i;
    end
  end

  assign dn_valid_o = valid_q;
  assign rem_o      = rem_q;
  assign word_o     = word_q;
  assign flags_o    = flags_q;

endmodule
`default_nettype wire

/* rtl/lpdr_sqrt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpdr_sqrt_cell: one digit step of the integer square root
// Brings down the next two bits of the quotient and decides one root bit.
// ----------------------------------------------------------------------------
module lpdr_sqrt_cell
  import lpdr_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     up_valid_i,
  output      logic                     up_ready_o,
  input  wire logic [LPDR_SQ_REM_W-1:0] rem_i,
  input  wire logic [LPDR_ALPHA_W-1:0]  root_i,
  input  wire logic [LPDR_WORD_W-1:0]   word_i,
  input  wire lpdr_flags_t              flags_i,
  output      logic                     dn_valid_o,
  input  wire logic                     dn_ready_i,
  output      logic [LPDR_SQ_REM_W-1:0] rem_o,
  output      logic [LPDR_ALPHA_W-1:0]  root_o,
  output      logic [LPDR_WORD_W-1:0]   word_o,
  output      lpdr_flags_t              flags_o
);

  logic                     valid_q;
  logic                     ld;
  logic [LPDR_SQ_REM_W-1:0] cur;
  logic [LPDR_SQ_REM_W-1:0] trial;
  logic                     fits;
  logic [LPDR_SQ_REM_W-1:0] rem_q;
  logic [LPDR_ALPHA_W-1:0]  root_q;
  logic [LPDR_WORD_W-1:0]   word_q;
  lpdr_flags_t              flags_q;

  assign up_ready_o = !valid_q || dn_ready_i;
  assign ld         = up_valid_i && up_ready_o;

  // Before a step the remainder is below 2^16, so its low bits suffice.
  always_comb begin
    cur   = {rem_i[LPDR_SQ_REM_W-3:0], word_i[LPDR_WORD_W-1 -: 2]};
    trial = {root_i, 2'b01};
    fits  = cur >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      rem_q   <= fits ? cur - trial : cur;
      root_q  <= {root_i[LPDR_ALPHA_W-2:0], fits};
      word_q  <= {word_i[LPDR_WORD_W-3:0], 2'b00};
      flags_q <= flags_i;
    end
  end

  assign dn_valid_o = valid_q;
  assign rem_o      = rem_q;
  assign root_o     = root_q;
  assign word_o     = word_q;
  assign flags_o    = flags_q;

endmodule
`default_nettype wire

/* rtl/line_point_distance_ratio.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_point_distance_ratio: distance of a line pixel from the first point
// Gives floor(sqrt(floor(d2 * 2^(2*FRAC_BITS) / D2))) for each pixel, with
// d2 the squared distance to the start point and D2 that of start to end,
// saturated at the largest alpha; a zero-length line gives alpha 0 and the
// degenerate flag.
//
//   channel   dir   payload                    handshake
//   point_i   in    point_x, point_y           valid/ready
//   ratio_o   out   alpha, degenerate          valid/ready
//   cfg       in    cfg_idx_i, cfg_data_i      cfg_we_i, no back-pressure
//
// One item enters per cycle unless stalled. Each item passes 53 register
// stages: four for the squared distance and set-up, 32 divider cells (one
// quotient bit each), 16 square-root cells (one root bit each) and the output
// register. Ready ripples back through every stage, so bubbles close up
// under a stall and the chain keeps taking items until every stage holds
// one. Reset clears the stage valid bits and sets all four registers to zero.
// ----------------------------------------------------------------------------
module line_point_distance_ratio
  import lpdr_pkg::*;
#(
  parameter int COORD_WIDTH = LPDR_COORD_WIDTH,
  parameter int FRAC_BITS   = LPDR_FRAC_BITS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  lpdr_point_if.sink                     point_i,
  lpdr_ratio_if.source                   ratio_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [LPDR_CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [COORD_WIDTH-1:0]    cfg_data_i
);

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = 2 * COORD_WIDTH + 1;
  localparam int NDC = LPDR_WORD_W;
  localparam int NSC = LPDR_ALPHA_W;

  // Configuration registers.
  logic [CW-1:0] start_x_q, start_y_q, end_x_q, end_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      end_x_q   <= '0;
      end_y_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_X: start_x_q <= cfg_data_i;
        REG_START_Y: start_y_q <= cfg_data_i;
        REG_END_X:   end_x_q   <= cfg_data_i;
        REG_END_Y:   end_y_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Squared span of the line, three stages behind the registers so that it
  // is settled by the time the first item after a write reaches the divider.
  logic signed [CW:0] sdx, sdy;
  logic [CW:0]        nsdx, nsdy;
  logic [CW-1:0]      span_ux_q, span_uy_q;
  logic [2*CW-1:0]    span_sqx_q, span_sqy_q;
  logic [DW-1:0]      span_q;

  always_comb begin
    sdx  = $signed({end_x_q[CW-1], end_x_q}) - $signed({start_x_q[CW-1], start_x_q});
    sdy  = $signed({end_y_q[CW-1], end_y_q}) - $signed({start_y_q[CW-1], start_y_q});
    nsdx = -sdx;
    nsdy = -sdy;
  end

  always_ff @(posedge clk_i) begin
    span_ux_q  <= sdx[CW] ? nsdx[CW-1:0] : sdx[CW-1:0];
    span_uy_q  <= sdy[CW] ? nsdy[CW-1:0] : sdy[CW-1:0];
    span_sqx_q <= {{CW{1'b0}}, span_ux_q} * {{CW{1'b0}}, span_ux_q};
    span_sqy_q <= {{CW{1'b0}}, span_uy_q} * {{CW{1'b0}}, span_uy_q};
    span_q     <= {1'b0, span_sqx_q} + {1'b0, span_sqy_q};
  end

  // Divider chain links; link 0 is the output of the front end.
  logic                   div_valid [0:NDC];
  logic                   div_ready [0:NDC];
  logic [DW-1:0]          div_rem   [0:NDC];
  logic [LPDR_WORD_W-1:0] div_word  [0:NDC];
  lpdr_flags_t            div_flags [0:NDC];

  lpdr_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_x_i  (start_x_q),
    .start_y_i  (start_y_q),
    .span_i     (span_q),
    .up_valid_i (point_i.valid),
    .up_ready_o (point_i.ready),
    .point_x_i  (point_i.point_x),
    .point_y_i  (point_i.point_y),
    .dn_valid_o (div_valid[0]),
    .dn_ready_i (div_ready[0]),
    .rem_o      (div_rem[0]),
    .word_o     (div_word[0]),
    .flags_o    (div_flags[0])
  );

  for (genvar g = 0; g < NDC; g++) begin : g_div
    lpdr_div_cell #(
      .SPAN_WIDTH (DW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .span_i     (span_q),
      .up_valid_i (div_valid[g]),
      .up_ready_o (div_ready[g]),
      .rem_i      (div_rem[g]),
      .word_i     (div_word[g]),
      .flags_i    (div_flags[g]),
      .dn_valid_o (div_valid[g+1]),
      .dn_ready_i (div_ready[g+1]),
      .rem_o      (div_rem[g+1]),
      .word_o     (div_word[g+1]),
      .flags_o    (div_flags[g+1])
    );
  end

  // Square-root chain links; link 0 takes the quotient from the divider.
  logic                     sq_valid [0:NSC];
  logic                     sq_ready [0:NSC];
  logic [LPDR_SQ_REM_W-1:0] sq_rem   [0:NSC];
  logic [LPDR_ALPHA_W-1:0]  sq_root  [0:NSC];
  logic [LPDR_WORD_W-1:0]   sq_word  [0:NSC];
  lpdr_flags_t              sq_flags [0:NSC];

  assign sq_valid[0]    = div_valid[NDC];
  assign div_ready[NDC] = sq_ready[0];
  assign sq_rem[0]      = '0;
  assign sq_root[0]     = '0;
  assign sq_word[0]     = div_word[NDC];
  assign sq_flags[0]    = div_flags[NDC];

  for (genvar g = 0; g < NSC; g++) begin : g_sqrt
    lpdr_sqrt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (sq_valid[g]),
      .up_ready_o (sq_ready[g]),
      .rem_i      (sq_rem[g]),
      .root_i     (sq_root[g]),
      .word_i     (sq_word[g]),
      .flags_i    (sq_flags[g]),
      .dn_valid_o (sq_valid[g+1]),
      .dn_ready_i (sq_ready[g+1]),
      .rem_o      (sq_rem[g+1]),
      .root_o     (sq_root[g+1]),
      .word_o     (sq_word[g+1]),
      .flags_o    (sq_flags[g+1])
    );
  end

  // Output register: degenerate lines give zero, a saturated quotient
  // gives the largest alpha.
  logic                    out_valid_q;
  logic                    out_ready;
  logic [LPDR_ALPHA_W-1:0] alpha_q;
  logic                    degen_q;

  assign out_ready     = !out_valid_q || ratio_o.ready;
  assign sq_ready[NSC] = out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= sq_valid[NSC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && sq_valid[NSC]) begin
      degen_q <= sq_flags[NSC].degen;
      if (sq_flags[NSC].degen) begin
        alpha_q <= '0;
      end else if (sq_flags[NSC].sat) begin
        alpha_q <= LPDR_ALPHA_MAX;
      end else begin
        alpha_q <= sq_root[NSC];
      end
    end
  end

  assign ratio_o.valid      = out_valid_q;
  assign ratio_o.alpha      = alpha_q;
  assign ratio_o.degenerate = degen_q;

`ifndef SYNTHESIS
  // With the output register empty, no stage can hold back the input.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> point_i.ready)
    else $error("input not ready although the output register is empty");

  // An unsaturated item enters the divider with a remainder below the span.
  a_div_entry_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_valid[0] && !div_flags[0].sat) |-> (div_rem[0] < span_q))
    else $error("divider entry remainder not below the span");

  // A degenerate result can only come from a zero span.
  a_degen_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ratio_o.valid && ratio_o.degenerate) |-> (span_q == '0))
    else $error("degenerate result with a non-zero span");

  // The last root cell never holds a remainder above twice its root.
  a_root_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_valid[NSC] && !sq_flags[NSC].sat && !sq_flags[NSC].degen)
      |-> (sq_rem[NSC] <= {1'b0, sq_root[NSC], 1'b0}))
    else $error("square root remainder above twice the root");
`endif

endmodule
`default_nettype wire

/* tb/tb_line_point_distance_ratio.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_point_distance_ratio: self-checking bench of the distance ratio block
// Programs a line's end points, streams pixel coordinates through the point
// channel and checks each ratio item against a bit-exact integer prediction of
// floor(sqrt(d2 * 2^(2*FRAC) / D2)) with saturation and the zero-length flag.
// Directed items cover the extremes and special cases, random lines follow,
// with bursts of idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_line_point_distance_ratio;
  import lpdr_pkg::*;

  localparam int CW          = LPDR_COORD_WIDTH;
  localparam int PIPE_SLACK  = 64;     // a little over the 53-stage chain
  localparam int HOLD_CYCLES = 240;    // long enough to fill every stage
  localparam int DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic [LPDR_ALPHA_W-1:0] alpha;
    logic                    degenerate;
  } ratio_t;

  typedef enum int {LINE_WIDE, LINE_SHORT, LINE_POINT} line_kind_e;

  logic clk_i;
  logic rst_ni;
  logic                      cfg_we;
  logic [LPDR_CFG_IDX_W-1:0] cfg_idx;
  logic [CW-1:0]             cfg_data;

  lpdr_point_if #(.COORD_WIDTH(CW)) point_if ();
  lpdr_ratio_if                     ratio_if ();

  // Mirror of the line registers, as the predictor sees them.
  logic signed [CW-1:0] line_sx, line_sy, line_ex, line_ey;

  ratio_t expected_ratios[$];
  int     mismatch_count;
  bit     src_idle_en;
  bit     sink_idle_en;
  int     hold_seq;
  int     hold_seen;
  int     hold_left;
  int     stall_left;

  line_point_distance_ratio #(
    .COORD_WIDTH(CW),
    .FRAC_BITS  (LPDR_FRAC_BITS)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .point_i   (point_if),
    .ratio_o   (ratio_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // Clock, 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Squared Euclidean distance between two points, exact.
  function automatic longint unsigned sq_distance(input logic signed [CW-1:0] ax,
                                                   input logic signed [CW-1:0] ay,
                                                   input logic signed [CW-1:0] bx,
                                                   input logic signed [CW-1:0] by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return longint'(dx * dx + dy * dy);
  endfunction

  // Expected ratio item for one pixel under the current line.
  function automatic ratio_t predict_ratio(input logic signed [CW-1:0] px,
                                           input logic signed [CW-1:0] py);
    longint unsigned span, pix_d2, quo, root, trial;
    ratio_t          r;
    span         = sq_distance(line_ex, line_ey, line_sx, line_sy);
    r.degenerate = (span == 0);
    r.alpha      = '0;
    if (span != 0) begin
      pix_d2 = sq_distance(px, py, line_sx, line_sy);
      quo    = (pix_d2 << (2 * LPDR_FRAC_BITS)) / span;
      if (quo >= (64'd1 << LPDR_WORD_W)) begin
        r.alpha = LPDR_ALPHA_MAX;
      end else begin
        // Bit-by-bit integer square root of the 32-bit quotient.
        root = 0;
        for (int b = LPDR_ALPHA_W - 1; b >= 0; b--) begin
          trial = root | (64'd1 << b);
          if (trial * trial <= quo) root = trial;
        end
        r.alpha = root[LPDR_ALPHA_W-1:0];
      end
    end
    return r;
  endfunction

  // Appends the expectation for an item that the block has taken.
  function automatic void queue_expected(input ratio_t r);
    expected_ratios = {expected_ratios, r};
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    return CW'($urandom_range(0, 16'hFFFF));
  endfunction

  // Compares one ratio item with the oldest expectation.
  task automatic check_ratio(input logic [LPDR_ALPHA_W-1:0] alpha, input logic degenerate);
    ratio_t exp_r;
    if (expected_ratios.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected ratio item alpha=%0d degenerate=%0b",
                 $realtime, alpha, degenerate);
    end else begin
      exp_r = expected_ratios.pop_front();
      if (alpha !== exp_r.alpha || degenerate !== exp_r.degenerate) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: ratio mismatch: exp alpha=%0d degen=%0b, got alpha=%0d degen=%0b",
                   $realtime, exp_r.alpha, exp_r.degenerate, alpha, degenerate);
      end
    end
  endtask

  // Output side: checks accepted items and drives ready with idle bursts and
  // the long hold-off that a test can request.
  always @(posedge clk_i) begin
    if (ratio_if.valid && ratio_if.ready) check_ratio(ratio_if.alpha, ratio_if.degenerate);
    if (!rst_ni) begin
      ratio_if.ready <= 1'b0;
    end else if (hold_seen != hold_seq) begin
      hold_seen      <= hold_seq;
      hold_left      <= HOLD_CYCLES;
      ratio_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left      <= hold_left - 1;
      ratio_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left     <= stall_left - 1;
      ratio_if.ready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left     <= $urandom_range(0, 7);
      ratio_if.ready <= 1'b0;
    end else begin
      ratio_if.ready <= 1'b1;
    end
  end

  // Offers one pixel, after an optional idle burst, and waits until taken.
  task automatic send_point(input logic signed [CW-1:0] px, input logic signed [CW-1:0] py);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      point_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    point_if.valid   <= 1'b1;
    point_if.point_x <= px;
    point_if.point_y <= py;
    do @(posedge clk_i); while (!point_if.ready);
    queue_expected(predict_ratio(px, py));
  endtask

  // Stops offering items and waits until the chain has emptied.
  task automatic wait_ratios_drained();
    point_if.valid <= 1'b0;
    while (expected_ratios.size() != 0) @(posedge clk_i);
    repeat (PIPE_SLACK) @(posedge clk_i);
  endtask

  // Programs all four line registers while the block is idle.
  task automatic set_line(input logic signed [CW-1:0] sx, input logic signed [CW-1:0] sy,
                          input logic signed [CW-1:0] ex, input logic signed [CW-1:0] ey);
    wait_ratios_drained();
    cfg_we <= 1'b1; cfg_idx <= REG_START_X; cfg_data <= sx;
    @(posedge clk_i);
    cfg_idx <= REG_START_Y; cfg_data <= sy;
    @(posedge clk_i);
    cfg_idx <= REG_END_X; cfg_data <= ex;
    @(posedge clk_i);
    cfg_idx <= REG_END_Y; cfg_data <= ey;
    @(posedge clk_i);
    cfg_we  <= 1'b0;
    line_sx = sx;
    line_sy = sy;
    line_ex = ex;
    line_ey = ey;
  endtask

  // Mostly pixels along the programmed line, some near the start point and
  // some anywhere in the coordinate range.
  task automatic send_line_points(input int count);
    longint dx, dy, n, k, px, py;
    int     pick;
    dx = longint'(line_ex) - longint'(line_sx);
    dy = longint'(line_ey) - longint'(line_sy);
    n  = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx) : (dy < 0 ? -dy : dy);
    if (n == 0) n = 1;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        k  = $urandom_range(0, 32'(2 * n + 2));
        px = longint'(line_sx) + dx * k / n + longint'($urandom_range(0, 2)) - 1;
        py = longint'(line_sy) + dy * k / n + longint'($urandom_range(0, 2)) - 1;
      end else if (pick < 85) begin
        px = longint'(line_sx) + longint'($urandom_range(0, 32'(2 * n))) - n;
        py = longint'(line_sy) + longint'($urandom_range(0, 32'(2 * n))) - n;
      end else begin
        px = rand_coord();
        py = rand_coord();
      end
      send_point(clamp_coord(px), clamp_coord(py));
    end
  endtask

  // Zero-length lines: the reset state and a coincident non-zero pair.
  task automatic test_zero_length();
    send_point(16'sd0, 16'sd0);
    send_point(16'sh7FFF, 16'sh8000);
    send_point(16'sh8000, 16'sh7FFF);
    set_line(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_point(16'sd0, 16'sd0);
    send_point(16'sh7FFF, 16'sh8000);
  endtask

  // Corner-to-corner line, the longest one there is.
  task automatic test_extreme_line();
    set_line(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    send_point(16'sh8000, 16'sh8000);
    send_point(16'sh7FFF, 16'sh7FFF);
    send_point(-16'sd1, -16'sd1);
    send_point(16'sh7FFF, 16'sh8000);
    send_point(16'sd0, 16'sd0);
  endtask

  // Ratios at, just below and far beyond two.
  task automatic test_saturation();
    set_line(16'sd0, 16'sd0, 16'sd1, 16'sd0);
    send_point(16'sd1, 16'sd0);
    send_point(16'sd2, 16'sd0);
    send_point(16'sd1, 16'sd1);
    send_point(-16'sd2, 16'sd0);
    send_point(16'sh7FFF, 16'sh7FFF);
    send_point(16'sd0, 16'sd0);
    set_line(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    send_point(16'sh7FFF, 16'sd0);
    send_point(16'sh8000, 16'sd0);
  endtask

  // Random lines of one kind, a fresh setting for each batch of pixels.
  task automatic test_random_lines(input line_kind_e kind, input int settings, input int count);
    logic signed [CW-1:0] sx, sy, ex, ey;
    for (int s = 0; s < settings; s++) begin
      sx = rand_coord();
      sy = rand_coord();
      case (kind)
        LINE_WIDE: begin
          ex = rand_coord();
          ey = rand_coord();
        end
        LINE_SHORT: begin
          ex = clamp_coord(longint'(sx) + longint'($urandom_range(0, 12)) - 6);
          ey = clamp_coord(longint'(sy) + longint'($urandom_range(0, 12)) - 6);
        end
        default: begin
          ex = sx;
          ey = sy;
        end
      endcase
      set_line(sx, sy, ex, ey);
      send_line_points(count);
    end
  endtask

  // The output holds off while pixels keep coming, so the chain fills up.
  task automatic test_output_stall();
    set_line(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    src_idle_en = 1'b0;
    hold_seq   <= hold_seq + 1;
    send_line_points(120);
    src_idle_en = 1'b1;
  endtask

  // Run-time limit.
  initial begin
    #5_000_000;
    $display("line_point_distance_ratio test failed");
    $finish;
  end

  initial begin
    int waited;
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = REG_START_X;
    cfg_data         = '0;
    point_if.valid   = 1'b0;
    point_if.point_x = '0;
    point_if.point_y = '0;
    ratio_if.ready   = 1'b0;
    line_sx          = '0;
    line_sy          = '0;
    line_ex          = '0;
    line_ey          = '0;
    mismatch_count   = 0;
    hold_seq         = 0;
    hold_seen        = 0;
    hold_left        = 0;
    stall_left       = 0;
    src_idle_en      = 1'b1;
    sink_idle_en     = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_length();
    test_extreme_line();
    test_saturation();
    test_random_lines(LINE_WIDE, 4, 150);
    test_random_lines(LINE_SHORT, 4, 150);
    test_random_lines(LINE_POINT, 1, 60);
    test_output_stall();

    // Closing stretch without any idling.
    wait_ratios_drained();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_random_lines(LINE_WIDE, 1, 150);
    test_random_lines(LINE_SHORT, 1, 150);

    point_if.valid <= 1'b0;
    waited = 0;
    while (expected_ratios.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (PIPE_SLACK) @(posedge clk_i);
    if (expected_ratios.size() == 0 && mismatch_count == 0) begin
      $display("line_point_distance_ratio test passed");
    end else begin
      $display("line_point_distance_ratio test failed");
    end
    $finish;
  end

endmodule
